/* rtl/core/dmc_pkg.sv */
// Shared types and constants for the direct-mapped cache.
// No dependencies; imported by dmc_ctrl and direct_mapped_cache.
package dmc_pkg;

  // Access command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Fixed widths of the item fields
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned EVICT_TAG_W = 22;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Control group from the sequencer to the datapath
  typedef struct packed {
    logic busy;
    logic clearing;
    logic accept;
    logic lookup;
  } ctrl_t;

endpackage

/* rtl/core/dmc_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read. Depends on nothing.
module dmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/dmc_ctrl.sv */
// Sequencer of the direct-mapped cache: clearing pass, idle, lookup.
// Depends on dmc_pkg for the state and control types.
module dmc_ctrl import dmc_pkg::*; #(
  parameter int unsigned INDEX_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output ctrl_t                 ctrl,
  output logic [INDEX_BITS-1:0] clr_index
);

  state_t state;
  state_t state_next;
  logic   clr_last;

  assign clr_last = &clr_index;

  // Advance state and the clearing pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_index <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_index <= clr_index + 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl = '0;
    case (state)
      ST_CLEAR: begin
        ctrl.busy     = 1'b1;
        ctrl.clearing = 1'b1;
      end
      ST_IDLE: begin
        ctrl.accept = start;
      end
      ST_LOOKUP: begin
        ctrl.busy   = 1'b1;
        ctrl.lookup = 1'b1;
      end
      default: ctrl.busy = 1'b1;
    endcase
  end

endmodule

/* rtl/core/direct_mapped_cache.sv */
// Top level of the direct-mapped, one-word-per-line cache.
// Depends on dmc_pkg, dmc_ram and dmc_ctrl.
//
//  channel   handshake                    payload
//  --------  ---------------------------  ---------------------------------------
//  access    start / busy                 command, address, data_word
//  result    done (one-cycle strobe)      hit, read_data, evict_valid, evict_data,
//                                         evict_tag, hit/miss/mem_read/mem_write
//  config    cfg_valid / cfg_ready        cfg_data (write_back_mode)
//
// For each item the line RAM is read at the accept edge; in the lookup state the
// line is checked, rewritten and the result registered, and done is high back in
// idle, when a new item may already be accepted. The single line RAM and its
// registered read set this order.
// After reset a clearing pass marks every one of the 2**INDEX_BITS lines invalid;
// busy is high throughout and configuration writes are still taken.
// The receiver cannot stall; done is high for exactly one cycle per result.
module direct_mapped_cache import dmc_pkg::*; #(
  parameter int unsigned INDEX_BITS       = 8,
  parameter int unsigned WORD_OFFSET_BITS = 0,
  parameter int unsigned BYTE_OFFSET_BITS = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   command,
  input  logic [ADDR_W-1:0]      address,
  input  logic [WORD_W-1:0]      data_word,
  output logic                   done,
  output logic                   hit,
  output logic [WORD_W-1:0]      read_data,
  output logic                   evict_valid,
  output logic [WORD_W-1:0]      evict_data,
  output logic [EVICT_TAG_W-1:0] evict_tag,
  output logic [WORD_W-1:0]      hit_count,
  output logic [WORD_W-1:0]      miss_count,
  output logic [WORD_W-1:0]      mem_read_count,
  output logic [WORD_W-1:0]      mem_write_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data
);

  localparam int unsigned LOW_SHIFT = BYTE_OFFSET_BITS + WORD_OFFSET_BITS;
  localparam int unsigned TAG_SHIFT = LOW_SHIFT + INDEX_BITS;
  localparam int unsigned TAG_W     = ADDR_W - TAG_SHIFT;
  localparam int unsigned LINE_W    = 2 + TAG_W + WORD_W;
  localparam int unsigned LINES     = 1 << INDEX_BITS;

  ctrl_t                  ctrl;
  logic [INDEX_BITS-1:0]  clr_index;
  logic                   write_back_mode;

  // Registered access
  logic                   cmd_q;
  logic [INDEX_BITS-1:0]  index_q;
  logic [TAG_W-1:0]       tag_q;
  logic [WORD_W-1:0]      word_q;

  // Line RAM ports
  logic                   ram_we;
  logic [INDEX_BITS-1:0]  ram_waddr;
  logic [LINE_W-1:0]      ram_wdata;
  logic [LINE_W-1:0]      ram_rdata;

  // Fields of the line read back
  logic                   line_valid;
  logic                   line_dirty;
  logic [TAG_W-1:0]       line_tag;
  logic [WORD_W-1:0]      line_data;

  logic                   lk_hit;
  logic                   lk_evict;
  logic                   new_dirty;
  logic [1:0]             wr_incr;

  dmc_ctrl #(
    .INDEX_BITS (INDEX_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .ctrl      (ctrl),
    .clr_index (clr_index)
  );

  dmc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINES)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctrl.accept),
    .raddr (address[LOW_SHIFT +: INDEX_BITS]),
    .rdata (ram_rdata)
  );

  assign busy      = ctrl.busy;
  assign cfg_ready = !ctrl.lookup;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      write_back_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      write_back_mode <= cfg_data;
    end
  end

  // Hold the accepted item for the lookup cycle
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_q   <= command;
      index_q <= address[LOW_SHIFT +: INDEX_BITS];
      tag_q   <= address[ADDR_W-1 : TAG_SHIFT];
      word_q  <= data_word;
    end
  end

  // Unpack the line: valid, dirty, tag, data
  assign line_valid = ram_rdata[LINE_W-1];
  assign line_dirty = ram_rdata[LINE_W-2];
  assign line_tag   = ram_rdata[WORD_W +: TAG_W];
  assign line_data  = ram_rdata[WORD_W-1:0];

  // Hit check and victim
  assign lk_hit    = line_valid && (line_tag == tag_q);
  assign lk_evict  = !lk_hit && line_valid && line_dirty;
  assign new_dirty = (cmd_q == CMD_WRITE) && write_back_mode;
  assign wr_incr   = {1'b0, lk_evict}
                   + {1'b0, (cmd_q == CMD_WRITE) && !write_back_mode};

  // Line write: clearing pass, refill on read miss, store on every write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = index_q;
    ram_wdata = {1'b1, new_dirty, tag_q, word_q};
    if (ctrl.clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_index;
      ram_wdata = '0;
    end else if (ctrl.lookup) begin
      ram_we = (cmd_q == CMD_WRITE) || !lk_hit;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count       <= '0;
      miss_count      <= '0;
      mem_read_count  <= '0;
      mem_write_count <= '0;
    end else if (ctrl.lookup) begin
      hit_count       <= hit_count + {{(WORD_W-1){1'b0}}, lk_hit};
      miss_count      <= miss_count + {{(WORD_W-1){1'b0}}, !lk_hit};
      mem_read_count  <= mem_read_count
                       + {{(WORD_W-1){1'b0}}, (cmd_q == CMD_READ) && !lk_hit};
      mem_write_count <= mem_write_count + {{(WORD_W-2){1'b0}}, wr_incr};
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.lookup;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctrl.lookup) begin
      hit         <= lk_hit;
      evict_valid <= lk_evict;
      evict_data  <= lk_evict ? line_data : '0;
      evict_tag   <= lk_evict ? EVICT_TAG_W'(line_tag) : '0;
      if (cmd_q == CMD_WRITE) begin
        read_data <= '0;
      end else begin
        read_data <= lk_hit ? line_data : word_q;
      end
    end
  end

endmodule
